// ===== sv/grid_footprint_rectangle_cover_assert.svh =====
// Assertion macros shared by the footprint rectangle cover RTL.
`ifndef GRID_FOOTPRINT_RECTANGLE_COVER_ASSERT_SVH
`define GRID_FOOTPRINT_RECTANGLE_COVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GFRC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gfrc same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GFRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gfrc next-cycle check failed");

`endif

// ===== sv/gfrc_pkg.sv =====
// Package with types and constants of the footprint rectangle cover block.
`timescale 1ns / 1ps
package gfrc_pkg;

   localparam int COORD_BITS = 16;
   localparam int MIN_POINTS = 4;

   typedef enum logic [2:0] {
      STATUS_RECT      = 3'd0,
      STATUS_TOO_FEW   = 3'd1,
      STATUS_SMALL     = 3'd2,
      STATUS_LARGE     = 3'd3,
      STATUS_UNCOVERED = 3'd4,
      STATUS_NONE      = 3'd5,
      STATUS_OVERFLOW  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_PRES_A,
      ST_PRES_B,
      ST_CELL,
      ST_COV_A,
      ST_COV_B,
      ST_START,
      ST_SCAN,
      ST_WIDE,
      ST_DOWN,
      ST_WAIT
   } state_type;

endpackage

// ===== sv/grid_footprint_rectangle_cover.sv =====
// Top level: collects footprint points and covers the filled cells with rectangles.
//
//  Channel | Direction | Contents
//  req     | in        | tdata = point_u[15:0], point_v[31:16]; tlast = last_point
//  rsp     | out       | tdata = status, corners (72 bits); tlast = final_result
//
// Points load one per cycle while req_tready is high. After the last point the block
// is busy: a check, a presence pass over the stored points, the cell map, a coverage
// pass (it stops at the first uncovered point), a start step, then a scan over the
// cells and, for each filled cell found, a widening and a downward growth of the
// rectangle, which then goes to the output register.
// Results wait there until taken. Reset is synchronous and clears all maps.
`timescale 1ns / 1ps
module grid_footprint_rectangle_cover
   import gfrc_pkg::*;
#(
   parameter int GRID_SPAN  = 8,
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // point_u [15:0], point_v [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status [2:0], corner_u_low [18:3], corner_v_low [34:19],
   // corner_u_high [50:35], corner_v_high [66:51], zero fill [71:67]
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int PW   = (GRID_SPAN > 1) ? $clog2(GRID_SPAN) : 1;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int CB   = COORD_BITS;

   typedef logic [GRID_SPAN-1:0][GRID_SPAN-1:0] map_type;

   // Registers
   state_type             state_ff, state_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in, idx_ff, idx_in;
   logic                  ovf_ff, ovf_in;
   logic signed [CB-1:0]  umin_ff, umin_in, umax_ff, umax_in;
   logic signed [CB-1:0]  vmin_ff, vmin_in, vmax_ff, vmax_in;
   map_type               pres_ff, pres_in, cell_ff, cell_in, work_ff, work_in;
   logic [PW-1:0]         cw_ff, cw_in, ch_ff, ch_in;
   logic [PW-1:0]         su_ff, su_in, sv_ff, sv_in, rw_ff, rw_in, rh_ff, rh_in;
   logic                  rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   status_type            rstat_ff, rstat_in;
   logic [CB-1:0]         rul_ff, rul_in, rvl_ff, rvl_in, ruh_ff, ruh_in, rvh_ff, rvh_in;

   // Point store
   logic [2*CB-1:0]       store_mem [MAX_POINTS];
   logic [2*CB-1:0]       rd_ff;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;

   // Derived values
   logic signed [CB-1:0]  in_u, in_v;
   logic [CB:0]           du, dv;
   logic [PW-1:0]         pu, pv;
   logic                  covered;
   map_type               cell_next, rect_mask, work_left;
   logic                  row_full;
   logic [PW:0]           wide_pos, down_row;
   logic                  scan_end;
   logic [PW-1:0]         su_adv, sv_adv;

   assign in_u = $signed(req_tdata[CB-1:0]);
   assign in_v = $signed(req_tdata[2*CB-1:CB]);
   assign du = {umax_ff[CB-1], umax_ff} - {umin_ff[CB-1], umin_ff};
   assign dv = {vmax_ff[CB-1], vmax_ff} - {vmin_ff[CB-1], vmin_ff};
   assign pu = PW'(rd_ff[CB-1:0] - umin_ff);
   assign pv = PW'(rd_ff[2*CB-1:CB] - vmin_ff);
   assign wide_pos = {1'b0, su_ff} + {1'b0, rw_ff};
   assign down_row = {1'b0, sv_ff} + {1'b0, rh_ff};

   // Store write on accepted points while the store has room, registered read at the walk index.
   assign wr_en   = req_tvalid && req_tready && (cnt_ff < CNTW'(MAX_POINTS));
   assign wr_addr = cnt_ff[AW-1:0];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_tdata[2*CB-1:0];
      end
      rd_ff <= store_mem[idx_ff[AW-1:0]];
   end

   // A cell is filled where all four of its corner points are present.
   always_comb begin
      cell_next = '0;
      for (int v = 0; v < GRID_SPAN - 1; v++) begin
         for (int u = 0; u < GRID_SPAN - 1; u++) begin
            cell_next[v][u] = (u < int'(cw_ff)) && (v < int'(ch_ff)) &&
                              pres_ff[v][u] && pres_ff[v][u+1] &&
                              pres_ff[v+1][u] && pres_ff[v+1][u+1];
         end
      end
   end

   // A point is covered if one of the up to four cells around it is filled.
   always_comb begin
      covered = 1'b0;
      if (pu < cw_ff && pv < ch_ff && cell_ff[pv][pu]) covered = 1'b1;
      if (pu != '0 && (pu - 1'b1) < cw_ff && pv < ch_ff && cell_ff[pv][pu - 1'b1])
         covered = 1'b1;
      if (pv != '0 && pu < cw_ff && (pv - 1'b1) < ch_ff && cell_ff[pv - 1'b1][pu])
         covered = 1'b1;
      if (pu != '0 && pv != '0 && (pu - 1'b1) < cw_ff && (pv - 1'b1) < ch_ff &&
          cell_ff[pv - 1'b1][pu - 1'b1])
         covered = 1'b1;
   end

   // Row test for growing downward, and the mask of the current rectangle.
   always_comb begin
      row_full  = 1'b1;
      rect_mask = '0;
      for (int a = 0; a < GRID_SPAN; a++) begin
         if (a >= int'(su_ff) && a < int'(wide_pos)) begin
            if (!work_ff[down_row[PW-1:0]][a]) row_full = 1'b0;
         end
      end
      for (int v = 0; v < GRID_SPAN; v++) begin
         for (int u = 0; u < GRID_SPAN; u++) begin
            rect_mask[v][u] = (u >= int'(su_ff)) && (u < int'(wide_pos)) &&
                              (v >= int'(sv_ff)) && (v < int'(down_row));
         end
      end
      work_left = work_ff & ~rect_mask;
   end

   // Scan position step: columns left to right, then rows top to bottom.
   always_comb begin
      su_adv   = su_ff + 1'b1;
      sv_adv   = sv_ff;
      scan_end = 1'b0;
      if (({1'b0, su_ff} + 1'b1) >= {1'b0, cw_ff}) begin
         su_adv = '0;
         sv_adv = sv_ff + 1'b1;
         if (({1'b0, sv_ff} + 1'b1) >= {1'b0, ch_ff}) scan_end = 1'b1;
      end
   end

   // Sequencer: next state and register updates.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;   idx_in = idx_ff;   ovf_in = ovf_ff;
      umin_in = umin_ff; umax_in = umax_ff; vmin_in = vmin_ff; vmax_in = vmax_ff;
      pres_in = pres_ff; cell_in = cell_ff; work_in = work_ff;
      cw_in = cw_ff; ch_in = ch_ff;
      su_in = su_ff; sv_in = sv_ff; rw_in = rw_ff; rh_in = rh_ff;
      rvalid_in = rvalid_ff; rlast_in = rlast_ff; rstat_in = rstat_ff;
      rul_in = rul_ff; rvl_in = rvl_ff; ruh_in = ruh_ff; rvh_in = rvh_ff;
      req_tready = (state_ff == ST_LOAD);

      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (cnt_ff == '0 && !ovf_ff) begin
                  umin_in = in_u; umax_in = in_u; vmin_in = in_v; vmax_in = in_v;
               end else begin
                  if (in_u < umin_ff) umin_in = in_u;
                  if (in_u > umax_ff) umax_in = in_u;
                  if (in_v < vmin_ff) vmin_in = in_v;
                  if (in_v > vmax_ff) vmax_in = in_v;
               end
               if (cnt_ff < CNTW'(MAX_POINTS)) cnt_in = cnt_ff + 1'b1;
               else ovf_in = 1'b1;
               if (req_tlast) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rul_in = '0; rvl_in = '0; ruh_in = '0; rvh_in = '0;
            rlast_in = 1'b1;
            if (!ovf_ff && cnt_ff < CNTW'(MIN_POINTS)) begin
               rstat_in = STATUS_TOO_FEW; rvalid_in = 1'b1; state_in = ST_WAIT;
            end else if (ovf_ff) begin
               rstat_in = STATUS_OVERFLOW; rvalid_in = 1'b1; state_in = ST_WAIT;
            end else if (du == '0 || dv == '0) begin
               rstat_in = STATUS_SMALL; rvalid_in = 1'b1; state_in = ST_WAIT;
            end else if (du > (CB+1)'(GRID_SPAN - 1) || dv > (CB+1)'(GRID_SPAN - 1)) begin
               rstat_in = STATUS_LARGE; rvalid_in = 1'b1; state_in = ST_WAIT;
            end else begin
               cw_in = du[PW-1:0]; ch_in = dv[PW-1:0];
               idx_in = '0; pres_in = '0;
               state_in = ST_PRES_A;
            end
         end
         ST_PRES_A: state_in = ST_PRES_B;
         ST_PRES_B: begin
            pres_in[pv][pu] = 1'b1;
            if (idx_ff + 1'b1 == cnt_ff) begin
               idx_in = '0; state_in = ST_CELL;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = ST_PRES_A;
            end
         end
         ST_CELL: begin
            cell_in = cell_next; state_in = ST_COV_A;
         end
         ST_COV_A: state_in = ST_COV_B;
         ST_COV_B: begin
            if (!covered) begin
               rstat_in = STATUS_UNCOVERED; rlast_in = 1'b1; rvalid_in = 1'b1;
               rul_in = '0; rvl_in = '0; ruh_in = '0; rvh_in = '0;
               state_in = ST_WAIT;
            end else if (idx_ff + 1'b1 == cnt_ff) begin
               idx_in = '0; state_in = ST_START;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = ST_COV_A;
            end
         end
         ST_START: begin
            if (cell_ff == '0) begin
               rstat_in = STATUS_NONE; rlast_in = 1'b1; rvalid_in = 1'b1;
               rul_in = '0; rvl_in = '0; ruh_in = '0; rvh_in = '0;
               state_in = ST_WAIT;
            end else begin
               work_in = cell_ff; su_in = '0; sv_in = '0; state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (work_ff[sv_ff][su_ff]) begin
               rw_in = PW'(1); state_in = ST_WIDE;
            end else if (scan_end) begin
               state_in = ST_LOAD;
               cnt_in = '0; ovf_in = 1'b0;
               umin_in = '0; umax_in = '0; vmin_in = '0; vmax_in = '0;
               pres_in = '0; cell_in = '0; work_in = '0;
            end else begin
               su_in = su_adv; sv_in = sv_adv;
            end
         end
         ST_WIDE: begin
            if (wide_pos < {1'b0, cw_ff} && work_ff[sv_ff][wide_pos[PW-1:0]]) begin
               rw_in = rw_ff + 1'b1;
            end else begin
               rh_in = PW'(1); state_in = ST_DOWN;
            end
         end
         ST_DOWN: begin
            if (down_row < {1'b0, ch_ff} && row_full) begin
               rh_in = rh_ff + 1'b1;
            end else begin
               work_in   = work_left;
               rstat_in  = STATUS_RECT;
               rul_in    = umin_ff + CB'(su_ff);
               rvl_in    = vmin_ff + CB'(sv_ff);
               ruh_in    = umin_ff + CB'(wide_pos);
               rvh_in    = vmin_ff + CB'(down_row);
               rlast_in  = (work_left == '0);
               rvalid_in = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               if (rlast_ff) begin
                  state_in = ST_LOAD;
                  cnt_in = '0; ovf_in = 1'b0;
                  umin_in = '0; umax_in = '0; vmin_in = '0; vmax_in = '0;
                  pres_in = '0; cell_in = '0; work_in = '0;
               end else begin
                  su_in = su_adv; sv_in = sv_adv; state_in = ST_SCAN;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         ovf_ff    <= 1'b0;
         umin_ff   <= '0;
         umax_ff   <= '0;
         vmin_ff   <= '0;
         vmax_ff   <= '0;
         pres_ff   <= '0;
         cell_ff   <= '0;
         work_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         ovf_ff    <= ovf_in;
         umin_ff   <= umin_in;
         umax_ff   <= umax_in;
         vmin_ff   <= vmin_in;
         vmax_ff   <= vmax_in;
         pres_ff   <= pres_in;
         cell_ff   <= cell_in;
         work_ff   <= work_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // Scan and result payload registers.
   always_ff @(posedge clock) begin
      cw_ff    <= cw_in;
      ch_ff    <= ch_in;
      su_ff    <= su_in;
      sv_ff    <= sv_in;
      rw_ff    <= rw_in;
      rh_ff    <= rh_in;
      rlast_ff <= rlast_in;
      rstat_ff <= rstat_in;
      rul_ff   <= rul_in;
      rvl_ff   <= rvl_in;
      ruh_ff   <= ruh_in;
      rvh_ff   <= rvh_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {5'b0, rvh_ff, ruh_ff, rvl_ff, rul_ff, rstat_ff};

   // Checks on the sequencer.
`include "grid_footprint_rectangle_cover_assert.svh"

   `GFRC_ASSERT_SAME(a_busy_while_pending, clock, reset, req_tready, !rsp_tvalid)
   `GFRC_ASSERT_SAME(a_reject_is_final, clock, reset,
      rsp_tvalid && (rsp_tdata[2:0] != STATUS_RECT), rsp_tlast)
   `GFRC_ASSERT_SAME(a_overflow_full, clock, reset, ovf_ff, cnt_ff == CNTW'(MAX_POINTS))
   `GFRC_ASSERT_NEXT(a_final_returns_idle, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tlast, req_tready)

endmodule
